[hdl/mcma_pkg.sv]
`default_nettype none
package mcma_pkg;

  localparam int CODE_W      = 10;
  localparam int CONV_W      = 2;
  localparam int AVG_W       = 13;
  localparam int CHAN_W      = 3;
  localparam int SLOT_W      = 6;
  localparam int MASK_W      = 8;
  localparam int CFG_INDEX_W = 1;

  localparam int CAPTURE_CHANNEL = 3;
  localparam int Q8_SHIFT        = 9;
  localparam int SCALE_STEP      = 73;
  localparam int FIFO_DEPTH      = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESSING_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MASK      = 1'd1;

  typedef struct packed {
    logic signed [AVG_W-1:0] average_q8;
    logic [CHAN_W-1:0]       full_channel;
    logic [CHAN_W-1:0]       next_channel;
    logic                    group_pin_level;
    logic                    capture_valid;
    logic [SLOT_W-1:0]       capture_slot;
    logic                    processed;
  } res_t;

endpackage
`default_nettype wire

[hdl/mcma_fifo.sv]
`default_nettype none
module mcma_fifo #(
  parameter int DEPTH = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mcma_pkg::res_t push_data,
  input  wire logic          pop,
  output logic               valid,
  output mcma_pkg::res_t     data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcma_pkg::res_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign valid  = (count != '0);
  assign data   = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hdl/mcma_div.sv]
`default_nettype none
module mcma_div #(
  parameter int WINDOW_LEN = 10,
  localparam int SUM_W = mcma_pkg::CODE_W + $clog2(WINDOW_LEN)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    sum_valid,
  input  wire logic signed [SUM_W-1:0] sum,
  input  wire mcma_pkg::res_t          side,
  output logic                         res_valid,
  output mcma_pkg::res_t               res
);

  localparam longint unsigned DIVISOR = longint'(WINDOW_LEN) * mcma_pkg::SCALE_STEP;
  localparam longint unsigned RECIP   =
    (longint'(1) << (SUM_W + mcma_pkg::Q8_SHIFT)) / DIVISOR;
  localparam int R_W = $clog2(RECIP + 1);
  localparam int D_W = $clog2(DIVISOR + 1);
  localparam int P_W = SUM_W + R_W;
  localparam int M_W = R_W + D_W;
  localparam int N_W = SUM_W + mcma_pkg::Q8_SHIFT;

  logic               a_valid;
  logic               a_neg;
  logic [SUM_W-1:0]   a_mag;
  mcma_pkg::res_t     a_side;

  logic               b_valid;
  logic               b_neg;
  logic [SUM_W-1:0]   b_mag;
  logic [P_W-1:0]     b_prod;
  mcma_pkg::res_t     b_side;

  logic               c_valid;
  logic               c_neg;
  logic [SUM_W-1:0]   c_mag;
  logic [R_W-1:0]     c_q;
  logic [N_W-1:0]     c_qd;
  mcma_pkg::res_t     c_side;

  logic [R_W-1:0]     q_est;
  logic [N_W-1:0]     num;
  logic [N_W-1:0]     rem;
  logic [R_W:0]       q_fix;
  logic signed [mcma_pkg::AVG_W-1:0] avg_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= sum_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  assign q_est = R_W'(b_prod >> SUM_W);

  always_ff @(posedge clk) begin
    a_neg  <= sum[SUM_W-1];
    a_mag  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    a_side <= side;

    b_neg  <= a_neg;
    b_mag  <= a_mag;
    b_prod <= P_W'(a_mag) * P_W'(RECIP);
    b_side <= a_side;

    c_neg  <= b_neg;
    c_mag  <= b_mag;
    c_q    <= q_est;
    c_qd   <= N_W'(M_W'(q_est) * M_W'(DIVISOR));
    c_side <= b_side;
  end

  always_comb begin
    num     = N_W'(c_mag) << mcma_pkg::Q8_SHIFT;
    rem     = num - c_qd;
    q_fix   = (R_W + 1)'(c_q) + (R_W + 1)'(rem >= N_W'(DIVISOR));
    avg_mag = mcma_pkg::AVG_W'(q_fix);
    res     = c_side;
    if (!c_side.processed) begin
      res.average_q8 = '0;
    end else if (c_neg) begin
      res.average_q8 = -avg_mag;
    end else begin
      res.average_q8 = avg_mag;
    end
  end

  assign res_valid = c_valid;

endmodule
`default_nettype wire

[hdl/multichannel_adc_moving_average.sv]
`default_nettype none
// Channel    Handshake                    Payload
// sample     sample_valid / sample_stall  sample_code, converter_channel
// result     result_valid / result_stall  average_q8, full_channel, next_channel,
//                                         group_pin_level, capture_valid,
//                                         capture_slot, processed
// config     cfg_write                    cfg_index, cfg_data
//
// One request per cycle sustained while sample_stall is low. The accepting edge
// issues the sum and history reads, the next cycle does the read-modify-write, the
// divider's a, b and c registers follow, then the result is queued until popped.
// Reset clears the per-channel slot pointers and fill flags at once; no sweep.
// A stalled result queue holds requests in flight; sample_stall rises when the
// queue plus the pipeline hold six requests.
module multichannel_adc_moving_average #(
  parameter int NUM_CHANNELS  = 8,
  parameter int WINDOW_LEN    = 10,
  parameter int CAPTURE_DEPTH = 50
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  sample_valid,
  output logic                                       sample_stall,
  input  wire logic [mcma_pkg::CODE_W-1:0]           sample_code,
  input  wire logic [mcma_pkg::CONV_W-1:0]           converter_channel,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic signed [mcma_pkg::AVG_W-1:0]          average_q8,
  output logic [mcma_pkg::CHAN_W-1:0]                full_channel,
  output logic [mcma_pkg::CHAN_W-1:0]                next_channel,
  output logic                                       group_pin_level,
  output logic                                       capture_valid,
  output logic [mcma_pkg::SLOT_W-1:0]                capture_slot,
  output logic                                       processed,
  input  wire logic                                  cfg_write,
  input  wire logic [mcma_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [mcma_pkg::MASK_W-1:0]           cfg_data
);

  localparam int ACT_W      = $clog2(NUM_CHANNELS);
  localparam int SL_W       = $clog2(WINDOW_LEN);
  localparam int HIST_DEPTH = NUM_CHANNELS * WINDOW_LEN;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int CP_W       = $clog2(CAPTURE_DEPTH);
  localparam int SUM_W      = mcma_pkg::CODE_W + $clog2(WINDOW_LEN);
  localparam int OCC_W      = $clog2(mcma_pkg::FIFO_DEPTH + 1);

  logic                       processing_enable;
  logic [mcma_pkg::MASK_W-1:0] channel_enable_mask;
  logic [ACT_W-1:0]           active_channel;
  logic [CP_W-1:0]            capture_pointer;
  logic [SL_W-1:0]            oldest_slot [NUM_CHANNELS];
  logic                       wrapped [NUM_CHANNELS];
  logic [OCC_W-1:0]           occ;

  logic signed [SUM_W-1:0]              sum_mem [NUM_CHANNELS];
  logic signed [mcma_pkg::CODE_W-1:0]   hist_mem [HIST_DEPTH];
  logic signed [SUM_W-1:0]              sum_rd;
  logic signed [mcma_pkg::CODE_W-1:0]   hist_rd;

  logic                       sample_accept;
  logic                       result_accept;
  logic                       do_update;
  logic [3:0]                 act4;
  logic [3:0]                 nx4;
  logic [ACT_W-1:0]           full;
  logic [ACT_W-1:0]           nx;
  logic [SL_W-1:0]            slot_cur;
  logic                       wrap_cur;
  logic [HA_W-1:0]            hidx;
  logic signed [mcma_pkg::CODE_W-1:0] centred;
  logic                       is_capture;
  mcma_pkg::res_t             side;

  logic                       s1_valid;
  logic                       s1_proc;
  logic [ACT_W-1:0]           s1_full;
  logic [HA_W-1:0]            s1_hidx;
  logic signed [mcma_pkg::CODE_W-1:0] s1_centred;
  logic                       s1_sum_ok;
  logic                       s1_hist_ok;
  mcma_pkg::res_t             s1_side;

  logic                       fwd_valid;
  logic [ACT_W-1:0]           fwd_ch;
  logic signed [SUM_W-1:0]    fwd_sum;

  logic signed [SUM_W-1:0]    base_sum;
  logic signed [mcma_pkg::CODE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    new_sum;
  logic                       s1_write;

  logic                       div_valid;
  mcma_pkg::res_t             div_res;
  mcma_pkg::res_t             out_res;

  function automatic logic [ACT_W-1:0] wrap_channel(input logic [4:0] raw);
    logic [4:0] r;
    r = raw;
    for (int i = 0; i < 4; i++) begin
      if (r >= 5'(NUM_CHANNELS)) begin
        r = r - 5'(NUM_CHANNELS);
      end
    end
    return ACT_W'(r);
  endfunction

  assign sample_stall  = (occ == OCC_W'(mcma_pkg::FIFO_DEPTH));
  assign sample_accept = sample_valid && !sample_stall;
  assign result_accept = result_valid && !result_stall;
  assign do_update     = sample_accept && processing_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      processing_enable   <= 1'b1;
      channel_enable_mask <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        mcma_pkg::REG_PROCESSING_ENABLE: processing_enable <= cfg_data[0];
        mcma_pkg::REG_CHANNEL_MASK:      channel_enable_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Round-robin scan: the nearest enabled channel after the active one wins.
  always_comb begin
    logic [4:0] c;
    nx = active_channel;
    for (int k = NUM_CHANNELS - 1; k >= 1; k--) begin
      c = 5'(active_channel) + 5'(k);
      if (c >= 5'(NUM_CHANNELS)) begin
        c = c - 5'(NUM_CHANNELS);
      end
      if (c < 5'(mcma_pkg::MASK_W) && channel_enable_mask[c[2:0]]) begin
        nx = ACT_W'(c);
      end
    end
  end

  always_comb begin
    act4       = 4'(active_channel);
    nx4        = 4'(nx);
    full       = wrap_channel({2'b00, act4[2], converter_channel});
    slot_cur   = oldest_slot[full];
    wrap_cur   = wrapped[full];
    hidx       = HA_W'(full * WINDOW_LEN + slot_cur);
    // centre at mid-scale: flip the top bit
    centred    = {~sample_code[mcma_pkg::CODE_W-1], sample_code[mcma_pkg::CODE_W-2:0]};
    is_capture = (5'(full) == 5'(mcma_pkg::CAPTURE_CHANNEL));

    side = '0;
    if (processing_enable) begin
      side.full_channel    = mcma_pkg::CHAN_W'(full);
      side.next_channel    = mcma_pkg::CHAN_W'(nx);
      side.group_pin_level = ~nx4[2];
      side.capture_valid   = is_capture;
      side.capture_slot    = is_capture ? mcma_pkg::SLOT_W'(capture_pointer) : '0;
      side.processed       = 1'b1;
    end else begin
      side.next_channel    = mcma_pkg::CHAN_W'(active_channel);
      side.group_pin_level = ~act4[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channel  <= '0;
      capture_pointer <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        oldest_slot[i] <= '0;
        wrapped[i]     <= 1'b0;
      end
    end else if (do_update) begin
      active_channel <= nx;
      if (slot_cur == SL_W'(WINDOW_LEN - 1)) begin
        oldest_slot[full] <= '0;
        wrapped[full]     <= 1'b1;
      end else begin
        oldest_slot[full] <= slot_cur + SL_W'(1);
      end
      if (is_capture) begin
        capture_pointer <= (capture_pointer == CP_W'(CAPTURE_DEPTH - 1)) ?
                           '0 : capture_pointer + CP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= sample_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_proc    <= processing_enable;
      s1_full    <= full;
      s1_hidx    <= hidx;
      s1_centred <= centred;
      s1_sum_ok  <= wrap_cur || (slot_cur != '0);
      s1_hist_ok <= wrap_cur;
      s1_side    <= side;
    end
  end

  always_comb begin
    s1_write   = s1_valid && s1_proc;
    base_sum   = (fwd_valid && fwd_ch == s1_full) ? fwd_sum :
                 (s1_sum_ok ? sum_rd : '0);
    old_sample = s1_hist_ok ? hist_rd : '0;
    new_sum    = base_sum - SUM_W'(old_sample) + SUM_W'(s1_centred);
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      sum_rd <= sum_mem[full];
    end
    if (s1_write) begin
      sum_mem[s1_full] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      hist_rd <= hist_mem[hidx];
    end
    if (s1_write) begin
      hist_mem[s1_hidx] <= s1_centred;
    end
  end

  // Forward the sum written at the edge where the next request read it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_write;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_ch  <= s1_full;
      fwd_sum <= new_sum;
    end
  end

  mcma_div #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .sum_valid(s1_valid),
    .sum      (new_sum),
    .side     (s1_side),
    .res_valid(div_valid),
    .res      (div_res)
  );

  mcma_fifo #(
    .DEPTH(mcma_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (div_valid),
    .push_data(div_res),
    .pop      (result_accept),
    .valid    (result_valid),
    .data     (out_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(sample_accept) - OCC_W'(result_accept);
    end
  end

  assign average_q8      = out_res.average_q8;
  assign full_channel    = out_res.full_channel;
  assign next_channel    = out_res.next_channel;
  assign group_pin_level = out_res.group_pin_level;
  assign capture_valid   = out_res.capture_valid;
  assign capture_slot    = out_res.capture_slot;
  assign processed       = out_res.processed;

  ap_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(mcma_pkg::FIFO_DEPTH))
    else $error("request count exceeds queue depth");

  ap_result_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> occ != '0)
    else $error("result queued with no request counted");

  ap_hist_index: assert property (@(posedge clk) disable iff (rst)
    do_update |-> (32'(hidx) < HIST_DEPTH) && (32'(full) < NUM_CHANNELS))
    else $error("history address out of range");

  ap_capture_ptr: assert property (@(posedge clk) disable iff (rst)
    32'(capture_pointer) < CAPTURE_DEPTH)
    else $error("capture pointer out of range");

endmodule
`default_nettype wire
